// ===== rtl/nst_pkg.sv =====
package nst_pkg;

  localparam int MELODY_DEPTH = 256;
  localparam int MEL_AW       = $clog2(MELODY_DEPTH);
  localparam int PITCH_COUNT  = 14;
  localparam int PIT_AW       = (PITCH_COUNT > 1) ? $clog2(PITCH_COUNT) : 1;
  localparam int CODE_STEP    = 14;
  localparam int CFG_W        = 9;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_MEL_WR  = 2'd1,
    CMD_PIT_WR  = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_e;

  typedef enum logic {
    CFG_SPE = 1'b0,
    CFG_LEN = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] period;
    logic [7:0]  chunk;
  } pitch_t;

  typedef struct packed {
    logic on;
    logic fetch;
  } s1_ctl_t;

endpackage

// ===== rtl/nst_in_if.sv =====
interface nst_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [7:0]  addr;
  logic [5:0]  note_code;
  logic [15:0] pitch_period;
  logic [7:0]  pitch_chunk;

  modport source (output valid, cmd, addr, note_code, pitch_period, pitch_chunk,
                  input ready);
  modport sink   (input valid, cmd, addr, note_code, pitch_period, pitch_chunk,
                  output ready);
endinterface

// ===== rtl/nst_out_if.sv =====
interface nst_out_if;
  logic        valid;
  logic        ready;
  logic        tone_on;
  logic [15:0] tone_period;
  logic [7:0]  tone_chunk;

  modport source (output valid, tone_on, tone_period, tone_chunk, input ready);
  modport sink   (input valid, tone_on, tone_period, tone_chunk, output ready);
endinterface

// ===== rtl/nst_melody_mem.sv =====
module nst_melody_mem
  import nst_pkg::*;
(
  input  logic       clk_i,
  input  logic       we_i,
  input  logic [7:0] waddr_i,
  input  logic [5:0] wdata_i,
  input  logic [7:0] raddr_i,
  output logic [5:0] rdata_o
);

  logic [5:0] mem_q [MELODY_DEPTH];
  logic [5:0] rdata_q;
  logic       wr_ok;
  logic       rd_ok;

  assign wr_ok = 32'(waddr_i) < MELODY_DEPTH;
  assign rd_ok = 32'(raddr_i) < MELODY_DEPTH;

  always_ff @(posedge clk_i) begin
    if (we_i && wr_ok) begin
      mem_q[MEL_AW'(waddr_i)] <= wdata_i;
    end
  end

  // write-through so a read of the entry written in the same cycle sees new data
  always_ff @(posedge clk_i) begin
    if (!rd_ok) begin
      rdata_q <= '0;
    end else if (we_i && wr_ok && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[MEL_AW'(raddr_i)];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/nst_pitch_mem.sv =====
module nst_pitch_mem
  import nst_pkg::*;
(
  input  logic       clk_i,
  input  logic       we_i,
  input  logic [7:0] waddr_i,
  input  pitch_t     wdata_i,
  input  logic       re_i,
  input  logic [5:0] raddr_i,
  output pitch_t     rdata_o
);

  pitch_t mem_q [PITCH_COUNT];
  pitch_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i && (32'(waddr_i) < PITCH_COUNT)) begin
      mem_q[PIT_AW'(waddr_i)] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (32'(raddr_i) < PITCH_COUNT) begin
        rdata_q <= mem_q[PIT_AW'(raddr_i)];
      end else begin
        rdata_q <= '0;
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/note_sequencer_tick.sv =====
// Pipeline: an accepted item is held in stage 1 and then in the output register.
// Throughput: one item per cycle while the output is not stalled; the melody read is
// prefetched at the next position every cycle and the pitch table read fills stage 1.
// Reset: asynchronous, active low; clears position, phase counters, current
// note, tempo 8 and length 1. Melody and pitch stores keep their contents.
module note_sequencer_tick
  import nst_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  nst_in_if.sink           in_i,
  nst_out_if.source        out_o
);

  logic [5:0]  spe_q, spe_d;
  logic [8:0]  len_q, len_d;
  logic [7:0]  rp_q, rp_d;
  logic [8:0]  sl_q, sl_d;
  logic [5:0]  gap_q, gap_d;
  logic        rest_q, rest_d;
  pitch_t      cur_q;
  logic        s1_v_q;
  s1_ctl_t     s1_q;
  logic        ov_q;
  logic        o_on_q;
  pitch_t      o_pitch_q;

  logic        in_fire;
  logic        s1_mv;
  cmd_e        cmd;
  logic [5:0]  code;
  logic [5:0]  pcode;
  logic [8:0]  slots;
  logic [5:0]  new_gap;
  logic [8:0]  new_sl;
  logic [8:0]  pos_inc;
  logic [7:0]  pos_nxt;
  logic        fetch;
  logic        on;
  pitch_t      pit_rdata;
  pitch_t      sel;

  assign in_fire    = in_i.valid & in_i.ready;
  assign s1_mv      = s1_v_q & (~ov_q | out_o.ready);
  assign in_i.ready = ~s1_v_q | s1_mv;
  assign cmd        = cmd_e'(in_i.cmd);

  // config
  always_comb begin
    spe_d = spe_q;
    len_d = len_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SPE: spe_d = cfg_data_i[5:0];
        CFG_LEN: len_d = cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // note decode from prefetched code
  always_comb begin
    if (code >= 6'(2 * CODE_STEP)) begin
      pcode = code - 6'(2 * CODE_STEP);
      slots = {1'b0, spe_q, 2'b00} + 9'(spe_q);
    end else if (code >= 6'(CODE_STEP)) begin
      pcode = code - 6'(CODE_STEP);
      slots = {2'b00, spe_q, 1'b0};
    end else begin
      pcode = code;
      slots = 9'(spe_q);
    end
  end

  assign new_gap = 6'((10'(slots) + 10'd7) >> 3);
  assign new_sl  = slots - 9'(new_gap);
  assign pos_inc = 9'(rp_q) + 9'd1;
  assign pos_nxt = (pos_inc >= len_q) ? 8'd0 : pos_inc[7:0];

  always_comb begin
    logic [8:0] sl_t;
    logic       rest_t;
    rp_d   = rp_q;
    sl_d   = sl_q;
    gap_d  = gap_q;
    rest_d = rest_q;
    fetch  = 1'b0;
    on     = 1'b0;
    sl_t   = sl_q;
    rest_t = rest_q;
    if (in_fire) begin
      case (cmd)
        CMD_RESTART: begin
          rp_d  = '0;
          sl_d  = '0;
          gap_d = '0;
        end
        CMD_TICK: begin
          if (sl_q == '0) begin
            if (gap_q != '0) begin
              sl_t   = 9'(gap_q);
              gap_d  = '0;
              rest_t = 1'b1;
            end else begin
              fetch  = 1'b1;
              rp_d   = pos_nxt;
              gap_d  = new_gap;
              sl_t   = new_sl;
              rest_t = 1'b0;
            end
          end
          rest_d = rest_t;
          on     = ~rest_t;
          sl_d   = (sl_t != '0) ? sl_t - 9'd1 : 9'd0;
        end
        default: ;
      endcase
    end
  end

  nst_melody_mem u_mel (
    .clk_i   (clk_i),
    .we_i    (in_fire && (cmd == CMD_MEL_WR)),
    .waddr_i (in_i.addr),
    .wdata_i (in_i.note_code),
    .raddr_i (rp_d),
    .rdata_o (code)
  );

  nst_pitch_mem u_pit (
    .clk_i   (clk_i),
    .we_i    (in_fire && (cmd == CMD_PIT_WR)),
    .waddr_i (in_i.addr),
    .wdata_i ({in_i.pitch_period, in_i.pitch_chunk}),
    .re_i    (fetch),
    .raddr_i (pcode),
    .rdata_o (pit_rdata)
  );

  assign sel = s1_q.fetch ? pit_rdata : cur_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spe_q  <= 6'd8;
      len_q  <= 9'd1;
      rp_q   <= '0;
      sl_q   <= '0;
      gap_q  <= '0;
      rest_q <= 1'b0;
      cur_q  <= '0;
      s1_v_q <= 1'b0;
      s1_q   <= '0;
      ov_q   <= 1'b0;
    end else begin
      spe_q  <= spe_d;
      len_q  <= len_d;
      rp_q   <= rp_d;
      sl_q   <= sl_d;
      gap_q  <= gap_d;
      rest_q <= rest_d;
      if (in_fire) begin
        s1_v_q <= 1'b1;
        s1_q   <= '{on: on, fetch: fetch};
      end else if (s1_mv) begin
        s1_v_q <= 1'b0;
      end
      if (s1_mv) begin
        ov_q <= 1'b1;
        if (s1_q.fetch) begin
          cur_q <= pit_rdata;
        end
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_mv) begin
      o_on_q    <= s1_q.on;
      o_pitch_q <= s1_q.on ? sel : '0;
    end
  end

  assign out_o.valid       = ov_q;
  assign out_o.tone_on     = o_on_q;
  assign out_o.tone_period = o_pitch_q.period;
  assign out_o.tone_chunk  = o_pitch_q.chunk;

`ifndef ASSERT_OFF
  a_gap_not_in_rest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gap_q != '0) |-> !rest_q)
    else $error("pending gap while resting");

  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && !s1_mv) |=> (s1_v_q && $stable(s1_q)))
    else $error("stage 1 lost while stalled");

  a_fire_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> s1_v_q)
    else $error("accepted beat not in stage 1");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench
  import nst_pkg::*;
();

  typedef struct packed {
    cmd_e        cmd;
    logic [7:0]  addr;
    logic [5:0]  code;
    logic [15:0] period;
    logic [7:0]  chunk;
  } in_beat_t;

  typedef struct packed {
    logic        on;
    logic [15:0] period;
    logic [7:0]  chunk;
  } tone_t;

  class tone_scoreboard;
    logic [5:0]  spe;
    logic [8:0]  mel_len;
    logic [5:0]  melody [MELODY_DEPTH];
    bit          mel_known [MELODY_DEPTH];
    pitch_t      pitches [PITCH_COUNT];
    bit          pitch_known [PITCH_COUNT];
    logic [7:0]  pos;
    logic [8:0]  slots_left;
    logic [5:0]  gap_left;
    bit          resting;
    pitch_t      cur;
    tone_t       tones_due [$];
    int          errors;
    int          n_beats;
    int          n_tone;
    int          n_rest;

    function new();
      spe = 8;
      mel_len = 1;
      pos = '0;
      slots_left = '0;
      gap_left = '0;
      resting = 0;
      cur = '0;
      foreach (mel_known[i]) mel_known[i] = 0;
      foreach (pitch_known[i]) pitch_known[i] = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_W-1:0] val);
      if (idx == CFG_SPE) spe = val[5:0];
      else mel_len = val;
    endfunction

    // split a note code into pitch index and length in eighths
    function void decode(logic [5:0] code, output int pidx, output int eighths);
      if (code >= 2 * CODE_STEP) begin
        pidx = int'(code) - 2 * CODE_STEP;
        eighths = 5;
      end else if (code >= CODE_STEP) begin
        pidx = int'(code) - CODE_STEP;
        eighths = 2;
      end else begin
        pidx = int'(code);
        eighths = 1;
      end
    endfunction

    function void fetch_note();
      logic [8:0] nxt;
      int pidx;
      int eighths;
      int slots;
      decode(melody[pos], pidx, eighths);
      nxt = {1'b0, pos} + 9'd1;
      if (nxt >= mel_len) nxt = '0;
      pos = nxt[7:0];
      slots = eighths * int'(spe);
      cur = (pidx < PITCH_COUNT) ? pitches[pidx] : '0;
      gap_left = 6'((slots + 7) >> 3);
      slots_left = 9'(slots - int'(gap_left));
      resting = 0;
    endfunction

    // next tick would read a store entry that holds nothing yet
    function bit unready_entry(output bit is_pitch, output int idx);
      int pidx;
      int eighths;
      is_pitch = 0;
      idx = 0;
      if (slots_left != 0 || gap_left != 0) return 0;
      if (!mel_known[pos]) begin
        idx = int'(pos);
        return 1;
      end
      decode(melody[pos], pidx, eighths);
      if (pidx < PITCH_COUNT && !pitch_known[pidx]) begin
        is_pitch = 1;
        idx = pidx;
        return 1;
      end
      return 0;
    endfunction

    function void note(in_beat_t b);
      tone_t t;
      t = '0;
      n_beats++;
      case (b.cmd)
        CMD_MEL_WR: begin
          melody[b.addr] = b.code;
          mel_known[b.addr] = 1;
        end
        CMD_PIT_WR: begin
          if (b.addr < PITCH_COUNT) begin
            pitches[b.addr] = '{period: b.period, chunk: b.chunk};
            pitch_known[b.addr] = 1;
          end
        end
        CMD_RESTART: begin
          pos = '0;
          slots_left = '0;
          gap_left = '0;
        end
        default: begin
          if (slots_left == 0) begin
            if (gap_left != 0) begin
              slots_left = 9'(gap_left);
              gap_left = '0;
              resting = 1;
            end else begin
              fetch_note();
            end
          end
          if (!resting) begin
            t = '{on: 1'b1, period: cur.period, chunk: cur.chunk};
            n_tone++;
          end else begin
            n_rest++;
          end
          if (slots_left != 0) slots_left--;
        end
      endcase
      tones_due.push_back(t);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check(tone_t got);
      tone_t want;
      if (tones_due.size() == 0) begin
        report("result beat with nothing expected");
        return;
      end
      want = tones_due.pop_front();
      if (got.on !== want.on)
        report($sformatf("tone_on %0b, want %0b", got.on, want.on));
      if (got.period !== want.period)
        report($sformatf("tone_period %h, want %h", got.period, want.period));
      if (got.chunk !== want.chunk)
        report($sformatf("tone_chunk %h, want %h", got.chunk, want.chunk));
    endtask

    function int pending();
      return tones_due.size();
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic             cfg_idx = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;
  bit               calm = 0;
  bit               long_hold_req = 0;
  int               hold_left = 0;
  tone_scoreboard   sb = new();

  nst_in_if  in_if ();
  nst_out_if out_if ();

  note_sequencer_tick u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #1 clk = ~clk;

  initial begin
    #500000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    forever begin
      repeat ($urandom_range(40, 160)) @(posedge clk);
      calm = ($urandom_range(0, 3) == 0);
    end
  end

  // sink side; long holds counted here
  initial begin
    int r;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_if.ready = 1'b0;
        hold_left--;
      end else if (long_hold_req) begin
        long_hold_req = 0;
        hold_left = 79;
        out_if.ready = 1'b0;
      end else if (calm) begin
        out_if.ready = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 2) begin
          hold_left = $urandom_range(8, 30);
          out_if.ready = 1'b0;
        end else begin
          out_if.ready = (r >= 25);
        end
      end
    end
  end

  always @(posedge clk) begin
    tone_t seen;
    if (rst_n && out_if.valid && out_if.ready) begin
      seen = {out_if.tone_on, out_if.tone_period, out_if.tone_chunk};
      sb.check(seen);
    end
  end

  function automatic int idle_gap();
    int r;
    if (calm || hold_left > 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic in_beat_t mk(cmd_e c, int a, int code, int per, int chk);
    in_beat_t b;
    b.cmd = c;
    b.addr = a[7:0];
    b.code = code[5:0];
    b.period = per[15:0];
    b.chunk = chk[7:0];
    return b;
  endfunction

  function automatic in_beat_t mel_beat(int a);
    int code;
    code = ($urandom_range(0, 9) == 0) ? $urandom_range(42, 63) : $urandom_range(0, 41);
    return mk(CMD_MEL_WR, a, code, $urandom, $urandom);
  endfunction

  function automatic in_beat_t pitch_beat(int a);
    return mk(CMD_PIT_WR, a, $urandom, $urandom, $urandom);
  endfunction

  function automatic in_beat_t rand_beat();
    int r;
    int span;
    r = $urandom_range(0, 99);
    if (r < 60) return mk(CMD_TICK, $urandom, $urandom, $urandom, $urandom);
    if (r < 80) begin
      span = (sb.mel_len == 0) ? 1 : (sb.mel_len > 256) ? 256 : int'(sb.mel_len);
      if ($urandom_range(0, 3) != 0) return mel_beat($urandom_range(0, span - 1));
      return mel_beat($urandom_range(0, 255));
    end
    if (r < 93) begin
      if ($urandom_range(0, 6) != 0) return pitch_beat($urandom_range(0, PITCH_COUNT - 1));
      return pitch_beat($urandom_range(PITCH_COUNT, 255));
    end
    return mk(CMD_RESTART, $urandom, $urandom, $urandom, $urandom);
  endfunction

  task automatic send_beat(in_beat_t b);
    int n;
    n = idle_gap();
    @(negedge clk);
    if (n > 0) begin
      in_if.valid = 1'b0;
      repeat (n) @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.cmd = b.cmd;
    in_if.addr = b.addr;
    in_if.note_code = b.code;
    in_if.pitch_period = b.period;
    in_if.pitch_chunk = b.chunk;
    do @(posedge clk); while (!in_if.ready);
    sb.note(b);
  endtask

  // fill any empty entry the next tick would fetch before sending the tick
  task automatic send_op(in_beat_t b);
    bit is_pitch;
    int idx;
    if (b.cmd == CMD_TICK)
      while (sb.unready_entry(is_pitch, idx))
        send_beat(is_pitch ? pitch_beat(idx) : mel_beat(idx));
    send_beat(b);
  endtask

  task automatic drain();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, int val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = val[CFG_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_reg(idx, val[CFG_W-1:0]);
  endtask

  task automatic run_directed();
    in_beat_t tick;
    tick = mk(CMD_TICK, 0, 0, 0, 0);
    send_op(mk(CMD_PIT_WR, 0, 0, 16'hFFFF, 8'hFF));
    send_op(mk(CMD_PIT_WR, PITCH_COUNT - 1, 0, 0, 0));
    send_op(mk(CMD_PIT_WR, 1, 0, 16'hA5A5, 8'h5A));
    send_op(mk(CMD_PIT_WR, PITCH_COUNT, 0, 16'h1234, 8'h12));
    send_op(mk(CMD_PIT_WR, 255, 63, 16'h5A5A, 8'hA5));
    send_op(mk(CMD_MEL_WR, 255, 28, 0, 0));
    send_op(mk(CMD_MEL_WR, 0, 0, 0, 0));
    // eighth note: tone slots, one rest slot, then a refetch
    repeat (9) send_op(tick);
    send_op(mk(CMD_MEL_WR, 0, 41, 0, 0));
    send_op(tick);
    send_op(mk(CMD_RESTART, 0, 0, 0, 0));
    send_op(tick);
    send_op(mk(CMD_MEL_WR, 0, 63, 0, 0));
    send_op(mk(CMD_RESTART, 0, 0, 0, 0));
    send_op(tick);
    send_op(tick);
    send_op(mk(CMD_MEL_WR, 0, CODE_STEP + 1, 0, 0));
    send_op(mk(CMD_RESTART, 0, 0, 0, 0));
    send_op(tick);
  endtask

  int tempo_set [7]  = '{2, 63, 1, 0, 5, 13, 37};
  int length_set [7] = '{5, 256, 0, 511, 17, 300, 3};
  int beats_set [7]  = '{90, 50, 60, 90, 90, 100, 70};

  initial begin
    in_if.valid = 1'b0;
    in_if.cmd = CMD_TICK;
    in_if.addr = '0;
    in_if.note_code = '0;
    in_if.pitch_period = '0;
    in_if.pitch_chunk = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    run_directed();
    for (int p = 0; p < 7; p++) begin
      drain();
      write_reg(CFG_SPE, tempo_set[p]);
      write_reg(CFG_LEN, length_set[p]);
      if (p == 0) long_hold_req = 1;
      repeat (beats_set[p]) send_op(rand_beat());
    end
    drain();
    repeat (6) @(posedge clk);

    $display("covered %0d beats over 8 tempo/length settings: %0d tone slots, %0d rest slots",
             sb.n_beats, sb.n_tone, sb.n_rest);
    $display("mismatches: %0d", sb.errors);
    if (sb.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/nst_pkg.sv
rtl/nst_in_if.sv
rtl/nst_out_if.sv
rtl/nst_melody_mem.sv
rtl/nst_pitch_mem.sv
rtl/note_sequencer_tick.sv
tb/testbench.sv
